@@ sv/fcdma_pkg.sv @@
`default_nettype none

package fcdma_pkg;

    localparam int DEFAULT_CHANNEL_COUNT = 4;

    localparam logic [2:0] ACT_WRITE_SOURCE  = 3'd0;
    localparam logic [2:0] ACT_WRITE_DEST    = 3'd1;
    localparam logic [2:0] ACT_WRITE_COUNT   = 3'd2;
    localparam logic [2:0] ACT_WRITE_CONTROL = 3'd3;
    localparam logic [2:0] ACT_START_EVENT   = 3'd4;
    localparam logic [2:0] ACT_STEP          = 3'd5;

    localparam int CTL_ENABLE_BIT = 15;
    localparam int CTL_WORD_BIT   = 10;
    localparam int CTL_REPEAT_BIT = 9;
    localparam int START_LSB      = 12;
    localparam int SRC_LSB        = 7;
    localparam int DST_LSB        = 5;

    localparam logic [1:0] MODE_UP     = 2'd0;
    localparam logic [1:0] MODE_DOWN   = 2'd1;
    localparam logic [1:0] MODE_FIXED  = 2'd2;
    localparam logic [1:0] MODE_RELOAD = 2'd3;

    localparam logic [1:0] START_IMMEDIATE = 2'd0;
    localparam logic [1:0] KIND_NONE       = 2'd0;

    localparam logic [16:0] BLOCK_DEFAULT      = 17'h04000;
    localparam logic [16:0] BLOCK_DEFAULT_LAST = 17'h10000;

    localparam logic [31:0] SIZE_HALF = 32'd2;
    localparam logic [31:0] SIZE_WORD = 32'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  channel;
        logic [31:0] value;
        logic [1:0]  trigger_kind;
    } item_t;

    typedef struct packed {
        logic        eligible;
        logic        enable_next;
    } lane_status_t;

    typedef struct packed {
        logic [31:0] read_address;
        logic [31:0] write_address;
        logic        word_size;
        logic        block_done;
    } lane_copy_t;

    typedef struct packed {
        logic        copy_valid;
        logic [1:0]  copy_channel;
        logic [31:0] read_address;
        logic [31:0] write_address;
        logic        word_size;
        logic        block_done;
        logic        any_enabled;
    } result_t;

    function automatic logic [31:0] step_address(input logic [31:0] addr,
                                                 input logic [1:0]  mode,
                                                 input logic [31:0] size);
        logic [31:0] r;
        unique case (mode)
            MODE_UP, MODE_RELOAD: r = addr + size;
            MODE_DOWN:            r = addr - size;
            default:              r = addr;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/fcdma_in_stage.sv @@
`default_nettype none

module fcdma_in_stage
    import fcdma_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic [4:0]  s_tuser,
    input  wire logic        take,
    output item_t            item,
    output logic             item_valid
);

    item_t item_reg;
    logic  valid_reg;

    assign s_tready   = !valid_reg || take;
    assign item       = item_reg;
    assign item_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            item_reg.action       <= s_tuser[2:0];
            item_reg.trigger_kind <= s_tuser[4:3];
            item_reg.channel      <= s_tdata[1:0];
            item_reg.value        <= s_tdata[33:2];
        end
    end

endmodule

`default_nettype wire

@@ sv/fcdma_channel.sv @@
`default_nettype none

module fcdma_channel
    import fcdma_pkg::*;
#(
    parameter int LANE_INDEX = 0,
    parameter bit IS_LAST    = 1'b0
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  advance,
    input  item_t      item,
    input  wire logic  grant,
    output lane_status_t status,
    output lane_copy_t copy
);

    logic [31:0] source_start_reg, source_start_next;
    logic [31:0] dest_start_reg, dest_start_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] control_reg, control_next;
    logic [31:0] cur_source_reg, cur_source_next;
    logic [31:0] cur_dest_reg, cur_dest_next;
    logic [16:0] units_reg, units_next;
    logic        pending_reg, pending_next;

    logic        hit;
    logic        enabled;
    logic [16:0] block_units;
    logic [31:0] size;
    logic [1:0]  src_mode;
    logic [1:0]  dst_mode;
    logic        last_unit;
    logic [15:0] new_control;

    assign hit         = (32'(item.channel) == LANE_INDEX);
    assign enabled     = control_reg[CTL_ENABLE_BIT];
    assign block_units = (count_reg != 16'd0) ? {1'b0, count_reg}
                       : (IS_LAST ? BLOCK_DEFAULT_LAST : BLOCK_DEFAULT);
    assign size        = control_reg[CTL_WORD_BIT] ? SIZE_WORD : SIZE_HALF;
    assign src_mode    = control_reg[SRC_LSB +: 2];
    assign dst_mode    = control_reg[DST_LSB +: 2];
    assign last_unit   = (units_reg <= 17'd1);
    assign new_control = item.value[15:0];

    assign copy.read_address  = cur_source_reg;
    assign copy.write_address = cur_dest_reg;
    assign copy.word_size     = control_reg[CTL_WORD_BIT];
    assign copy.block_done    = last_unit;

    assign status.eligible    = pending_reg && enabled;
    assign status.enable_next = control_next[CTL_ENABLE_BIT];

    always_comb begin
        source_start_next = source_start_reg;
        dest_start_next   = dest_start_reg;
        count_next        = count_reg;
        control_next      = control_reg;
        cur_source_next   = cur_source_reg;
        cur_dest_next     = cur_dest_reg;
        units_next        = units_reg;
        pending_next      = pending_reg;
        unique case (item.action)
            ACT_WRITE_SOURCE: begin
                if (hit) begin
                    source_start_next = item.value;
                end
            end
            ACT_WRITE_DEST: begin
                if (hit) begin
                    dest_start_next = item.value;
                end
            end
            ACT_WRITE_COUNT: begin
                if (hit) begin
                    count_next = item.value[15:0];
                end
            end
            ACT_WRITE_CONTROL: begin
                if (hit) begin
                    control_next = new_control;
                    if (!new_control[CTL_ENABLE_BIT]) begin
                        pending_next = 1'b0;
                    end else if (!enabled) begin
                        cur_source_next = source_start_reg;
                        cur_dest_next   = dest_start_reg;
                        units_next      = block_units;
                        if (new_control[START_LSB +: 2] == START_IMMEDIATE) begin
                            pending_next = 1'b1;
                        end
                    end
                end
            end
            ACT_START_EVENT: begin
                if (item.trigger_kind != KIND_NONE && enabled &&
                    control_reg[START_LSB +: 2] == item.trigger_kind) begin
                    pending_next = 1'b1;
                end
            end
            ACT_STEP: begin
                if (grant) begin
                    cur_source_next = step_address(cur_source_reg,
                        (src_mode == MODE_RELOAD) ? MODE_FIXED : src_mode, size);
                    cur_dest_next   = step_address(cur_dest_reg, dst_mode, size);
                    units_next      = last_unit ? 17'd0 : units_reg - 17'd1;
                    if (last_unit) begin
                        pending_next = 1'b0;
                        if (control_reg[CTL_REPEAT_BIT]) begin
                            if (dst_mode == MODE_RELOAD) begin
                                cur_dest_next = dest_start_reg;
                            end
                            units_next = block_units;
                        end else begin
                            control_next[CTL_ENABLE_BIT] = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_start_reg <= '0;
            dest_start_reg   <= '0;
            count_reg        <= '0;
            control_reg      <= '0;
            cur_source_reg   <= '0;
            cur_dest_reg     <= '0;
            units_reg        <= '0;
            pending_reg      <= 1'b0;
        end else if (advance) begin
            source_start_reg <= source_start_next;
            dest_start_reg   <= dest_start_next;
            count_reg        <= count_next;
            control_reg      <= control_next;
            cur_source_reg   <= cur_source_next;
            cur_dest_reg     <= cur_dest_next;
            units_reg        <= units_next;
            pending_reg      <= pending_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/fcdma_out_stage.sv @@
`default_nettype none

module fcdma_out_stage
    import fcdma_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  result_t          result,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    result_t result_reg;
    logic    valid_reg;

    assign m_tvalid = valid_reg;
    assign m_tuser  = result_reg.copy_valid;
    assign m_tlast  = result_reg.block_done;
    assign m_tdata  = {4'b0000,
                       result_reg.any_enabled,
                       result_reg.word_size,
                       result_reg.write_address,
                       result_reg.read_address,
                       result_reg.copy_channel};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

@@ sv/four_channel_dma_controller_unit.sv @@
`default_nettype none

// Four-channel DMA controller. Each input word writes a channel register, raises a start
// event or asks for one transfer step, and yields exactly one result word carrying the copy
// command (if any) and whether any channel is still enabled. A word is registered on entry,
// processed combinationally by the per-channel register lanes and the lowest-index priority
// pick, and registered again at the output, so the block takes one word per cycle while the
// output is not held back by m_tready; the address add and the pick are combinational.

module four_channel_dma_controller_unit
    import fcdma_pkg::*;
#(
    parameter int CHANNEL_COUNT = DEFAULT_CHANNEL_COUNT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // channel[1:0], value[33:2], zero[39:34]
    input  wire logic [4:0]  s_tuser,   // action[2:0], trigger_kind[4:3]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // copy_channel[1:0], read_address[33:2],
                                        // write_address[65:34], word_size[66],
                                        // any_enabled[67], zero[71:68]
    output logic             m_tlast,
    output logic             m_tuser    // copy_valid
);

    item_t        item;
    logic         item_valid;
    logic         advance;
    logic [CHANNEL_COUNT-1:0] grant;
    lane_status_t status [CHANNEL_COUNT];
    lane_copy_t   copy   [CHANNEL_COUNT];
    result_t      result;

    assign advance = item_valid && (!m_tvalid || m_tready);

    fcdma_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_lane
        fcdma_channel #(
            .LANE_INDEX (g),
            .IS_LAST    (g == CHANNEL_COUNT - 1)
        ) u_channel (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .item    (item),
            .grant   (grant[g]),
            .status  (status[g]),
            .copy    (copy[g])
        );
    end

    always_comb begin
        logic found;
        found = 1'b0;
        grant = '0;
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            if (status[i].eligible && !found) begin
                grant[i] = (item.action == ACT_STEP);
                found    = 1'b1;
            end
        end
    end

    always_comb begin
        result = '0;
        result.copy_valid = |grant;
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            if (grant[i]) begin
                result.copy_channel  = result.copy_channel | 2'(i);
                result.read_address  = result.read_address | copy[i].read_address;
                result.write_address = result.write_address | copy[i].write_address;
                result.word_size     = result.word_size | copy[i].word_size;
                result.block_done    = result.block_done | copy[i].block_done;
            end
            result.any_enabled = result.any_enabled | status[i].enable_next;
        end
    end

    fcdma_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_grant_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(grant))
        else $error("more than one channel granted");

    a_idle_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[66:0] == 67'd0 && !m_tlast))
        else $error("copy fields set without a copy command");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed word did not reach the output register");

endmodule

`default_nettype wire
